// ===== sv/mlt_pkg.sv =====
// Shared types and constants for the MAC learning table.
package mlt_pkg;

	localparam int MAC_W  = 48;
	localparam int PORT_W = 6;
	localparam int AGE_W  = 8;

	localparam logic [1:0] ACT_DROP    = 2'd0;
	localparam logic [1:0] ACT_FLOOD   = 2'd1;
	localparam logic [1:0] ACT_UNICAST = 2'd2;

	localparam logic             OP_TICK   = 1'b1;
	localparam logic [AGE_W-1:0] AGE_RESET = 8'd10;

	typedef struct packed {
		logic              is_tick;
		logic [PORT_W-1:0] port;
		logic [MAC_W-1:0]  src;
		logic [MAC_W-1:0]  dst;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [AGE_W-1:0]  age;
	} entry_t;

	// engine -> front
	typedef struct packed {
		logic pop;
		logic init_done;
	} eng_stat_t;

endpackage

// ===== sv/mac_learning_table_with_aging_top.sv =====
// Top level of the MAC learning table with aging.
//   channel | signals                                         | dir
//   input   | in_valid/in_ready, operation in_port src dst    | in
//   result  | out_valid/out_ready, action out_port learn_failed | out
//   config  | cfg_we, cfg_wdata (age_limit)                   | in
// Every beat runs one sequential scan over the table memory (one read port),
// then a write-back and the result load.
// After reset a clearing pass over the whole table runs; in_ready stays low.
// A two-beat input queue and the result register let each side stall on its own.
module mac_learning_table_with_aging_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [5:0]  in_port,
	input  logic [47:0] src_mac,
	input  logic [47:0] dst_mac,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [5:0]  out_port,
	output logic        learn_failed,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic [7:0]         age_limit_q, fresh_age;
	logic               q_valid;
	mlt_pkg::item_t     q_item;
	mlt_pkg::eng_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= mlt_pkg::AGE_RESET;
		end else if (cfg_we) begin
			age_limit_q <= cfg_wdata;
		end
	end

	// zero limit acts as one
	assign fresh_age = (age_limit_q == 8'd0) ? 8'd1 : age_limit_q;

	mlt_queue u_queue (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .in_port, .src_mac, .dst_mac,
		.stat, .q_valid, .q_item
	);

	mlt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk, .arst_n, .fresh_age, .q_valid, .q_item, .stat,
		.out_valid, .out_ready, .action, .out_port, .learn_failed
	);

endmodule

// ===== sv/mlt_queue.sv =====
// Front end: accepts input beats, classifies them and holds up to two in a queue.
module mlt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [5:0]         in_port,
	input  logic [47:0]        src_mac,
	input  logic [47:0]        dst_mac,
	input  mlt_pkg::eng_stat_t stat,
	output logic               q_valid,
	output mlt_pkg::item_t     q_item
);

	mlt_pkg::item_t slot0_q, slot1_q, new_item;
	logic [1:0]     count_q;
	logic           push, pop;

	assign new_item = '{is_tick: (operation == mlt_pkg::OP_TICK), port: in_port,
		src: src_mac, dst: dst_mac};
	assign in_ready = stat.init_done && (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign pop      = stat.pop;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (count_q == 2'd1) begin
				slot0_q <= new_item;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= new_item;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				slot0_q <= new_item;
			end else begin
				slot1_q <= new_item;
			end
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ===== sv/mlt_engine.sv =====
// Back end: table memory, scan sequencer for lookup/learn and aging, result register.
module mlt_engine #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         fresh_age,
	input  logic               q_valid,
	input  mlt_pkg::item_t     q_item,
	output mlt_pkg::eng_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         action,
	output logic [5:0]         out_port,
	output logic               learn_failed
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	mlt_pkg::entry_t mem [TABLE_DEPTH];
	mlt_pkg::entry_t rdata_s1, wdata;
	logic [IW-1:0]   waddr;
	logic            we;

	state_t          state_q;
	mlt_pkg::item_t  cur_q;
	logic [IW-1:0]   rd_addr_q, idx_s1;
	logic            rd_done_q, vld_s1;
	logic            src_hit_q, free_hit_q, dst_hit_q;
	logic [IW-1:0]   src_idx_q, free_idx_q;
	logic [5:0]      src_port_q, dst_port_q;
	logic            res_valid_q, res_failed_q;
	logic [1:0]      res_action_q;
	logic [5:0]      res_port_q;
	logic            can_out, learned;
	logic [1:0]      fin_action;
	logic [5:0]      fin_port;

	assign can_out   = !res_valid_q || out_ready;
	assign learned   = !src_hit_q && free_hit_q;
	assign stat.pop       = (state_q == ST_IDLE) && q_valid;
	assign stat.init_done = (state_q != ST_CLEAR);

	assign out_valid    = res_valid_q;
	assign action       = res_action_q;
	assign out_port     = res_port_q;
	assign learn_failed = res_failed_q;

	always_comb begin
		fin_action = mlt_pkg::ACT_FLOOD;
		fin_port   = '0;
		if (cur_q.is_tick) begin
			fin_action = mlt_pkg::ACT_DROP;
		end else if (learned && cur_q.dst == cur_q.src) begin
			// freshly learned source is its own destination, on the arrival port
			fin_action = mlt_pkg::ACT_DROP;
		end else if (dst_hit_q) begin
			if (dst_port_q == cur_q.port) begin
				fin_action = mlt_pkg::ACT_DROP;
			end else begin
				fin_action = mlt_pkg::ACT_UNICAST;
				fin_port   = dst_port_q;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = rd_addr_q;
		wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_SCAN: begin
				if (cur_q.is_tick && vld_s1 && rdata_s1.valid) begin
					we    = 1'b1;
					waddr = idx_s1;
					wdata = rdata_s1;
					if (rdata_s1.age <= 8'd1) begin
						wdata.valid = 1'b0;
						wdata.age   = '0;
					end else begin
						wdata.age = rdata_s1.age - 8'd1;
					end
				end
			end
			ST_FINISH: begin
				if (can_out && !cur_q.is_tick && (src_hit_q || free_hit_q)) begin
					we    = 1'b1;
					waddr = src_hit_q ? src_idx_q : free_idx_q;
					wdata = '{valid: 1'b1, mac: cur_q.src,
						port: src_hit_q ? src_port_q : cur_q.port, age: fresh_age};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			rd_addr_q    <= '0;
			rd_done_q    <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			res_valid_q  <= 1'b0;
			res_action_q <= '0;
			res_port_q   <= '0;
			res_failed_q <= 1'b0;
			src_hit_q    <= 1'b0;
			free_hit_q   <= 1'b0;
			dst_hit_q    <= 1'b0;
			src_idx_q    <= '0;
			free_idx_q   <= '0;
			src_port_q   <= '0;
			dst_port_q   <= '0;
			cur_q        <= '0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					rd_addr_q <= rd_addr_q + 1'b1;
					if (rd_addr_q == LAST) begin
						rd_addr_q <= '0;
						state_q   <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						cur_q      <= q_item;
						rd_addr_q  <= '0;
						rd_done_q  <= 1'b0;
						src_hit_q  <= 1'b0;
						free_hit_q <= 1'b0;
						dst_hit_q  <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!rd_done_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= rd_addr_q;
						rd_addr_q <= rd_addr_q + 1'b1;
						if (rd_addr_q == LAST) begin
							rd_done_q <= 1'b1;
						end
					end
					if (vld_s1 && !cur_q.is_tick) begin
						if (rdata_s1.valid) begin
							if (!src_hit_q && rdata_s1.mac == cur_q.src) begin
								src_hit_q  <= 1'b1;
								src_idx_q  <= idx_s1;
								src_port_q <= rdata_s1.port;
							end
							if (!dst_hit_q && rdata_s1.mac == cur_q.dst) begin
								dst_hit_q  <= 1'b1;
								dst_port_q <= rdata_s1.port;
							end
						end else if (!free_hit_q) begin
							free_hit_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					if (rd_done_q && !vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_out) begin
						res_valid_q  <= 1'b1;
						res_action_q <= fin_action;
						res_port_q   <= fin_port;
						res_failed_q <= !cur_q.is_tick && !src_hit_q && !free_hit_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/mlt_checker.sv =====
// Port-level checker for the MAC learning table, bound to the top level.
module mlt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] action,
	input logic [5:0] out_port,
	input logic       learn_failed
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(out_port) &&
			$stable(learn_failed))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action == mlt_pkg::ACT_DROP || action == mlt_pkg::ACT_FLOOD ||
			action == mlt_pkg::ACT_UNICAST)
		else $error("bad action code");

	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != mlt_pkg::ACT_UNICAST |-> out_port == 6'd0)
		else $error("out_port set without unicast");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({action, out_port, learn_failed}))
		else $error("unknown bits in result");

endmodule

bind mac_learning_table_with_aging_top mlt_checker u_mlt_checker (
	.clk, .arst_n, .out_valid, .out_ready, .action, .out_port, .learn_failed
);
